// ----- sv/md5_message_digest_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef MD5_MESSAGE_DIGEST_MACROS_SVH
`define MD5_MESSAGE_DIGEST_MACROS_SVH

// Clocked check, ignored while reset is high.
`define MD5_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("md5 check failed");

// Clocked check that also holds during reset.
`define MD5_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("md5 check failed");

`endif

// ----- sv/md5_pkg.sv -----
package md5_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOAD,
    S_CROUND,
    S_CADD,
    S_PAD_FIRST,
    S_PAD_ZERO,
    S_LEN_LO,
    S_LEN_HI,
    S_OUT
  } state_t;

  // where to go once a compression finishes
  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD_FIRST,
    RET_PAD_ZERO,
    RET_OUT
  } ret_t;

  typedef struct packed {
    logic take_byte;
    logic load_work;
    logic do_round;
    logic add_chain;
    logic pad_first;
    logic pad_zero;
    logic pad_unwrap;
    logic len_lo;
    logic len_hi;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fill_full;
    logic round_last;
    logic pad_wrap;
    logic widx_is_len;
    logic widx_is_zero;
    logic word_last;
  } status_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [3:0]  LEN_WORD = 4'd14;
  localparam logic [1:0]  LAST_WORD = 2'd3;

  function automatic logic [31:0] k_const(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478; 6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB; 6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF; 6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613; 6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8; 6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E; 6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87; 6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942; 6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60; 6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039; 6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7; 6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F; 6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB; default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(5 * r[3:0] + 1);
      2'd2:    g = 4'(3 * r[3:0] + 5);
      default: g = 4'(7 * r[3:0]);
    endcase
    return g;
  endfunction

endpackage

// ----- sv/md5_message_digest.sv -----
// Channel | Dir | tdata                         | tuser           | tlast
// s_      | in  | [7:0] data_byte               | -               | last_byte
// m_      | out | [31:0] digest_word            | [1:0] word_index| final_word
//
// A plain byte is simply stored; a byte that fills the 64-byte block starts
// a compression (load, 64 rounds, chain add).
// A last byte adds padding steps (0x80, zero words, length) and one compression;
// when 0x80 lands in bytes 56..63 it adds more padding steps and two
// compressions; then four digest items follow.
// The single round unit computes one round per cycle.
// rst is synchronous, active high; it restores the MD5 initial chain.
// m_tready low holds the current digest item; s_tready stays low meanwhile.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast    // final_word
);
  import md5_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequencer: byte intake, padding steps, round counting, digest output
  md5_ctrl u_ctrl (
    .clk(clk), .rst(rst), .st(st), .cmd(cmd),
    .in_valid(s_tvalid), .in_last(s_tlast), .in_ready(s_tready),
    .out_valid(m_tvalid), .out_ready(m_tready)
  );

  // block buffer RAM, chain words, working words and counters
  md5_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .data_byte(s_tdata),
    .digest_word(m_tdata), .word_index(m_tuser), .final_word(m_tlast)
  );
endmodule

// ----- sv/md5_ram.sv -----
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/md5_dp.sv -----
module md5_dp (
  input  logic            clk,
  input  logic            rst,
  input  md5_pkg::cmd_t   cmd,
  output md5_pkg::status_t st,
  input  logic [7:0]      data_byte,
  output logic [31:0]     digest_word,
  output logic [1:0]      word_index,
  output logic            final_word
);
  import md5_pkg::*;

  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] acc, acc_next;
  logic [5:0]  fill;
  logic [63:0] bits;
  logic [5:0]  round;
  logic [3:0]  widx;
  logic        pad_wrap;
  logic [1:0]  out_idx;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata, pad_word;
  logic [31:0] f, t, rot, b_new;
  logic [63:0] rot2;

  md5_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // byte lane insert
  always_comb begin
    acc_next = acc;
    acc_next[8*fill[1:0] +: 8] = data_byte;
  end

  // first padding word: earlier bytes, 0x80, then zeros
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < fill[1:0]) pad_word[8*j +: 8] = acc[8*j +: 8];
      else if (2'(j) == fill[1:0]) pad_word[8*j +: 8] = PAD_BYTE;
      else pad_word[8*j +: 8] = 8'h00;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = widx;
    ram_wdata = 32'h0;
    if (cmd.take_byte) begin
      ram_we    = (fill[1:0] == 2'd3);
      ram_waddr = fill[5:2];
      ram_wdata = acc_next;
    end else if (cmd.pad_first) begin
      ram_we    = 1'b1;
      ram_waddr = fill[5:2];
      ram_wdata = pad_word;
    end else if (cmd.pad_zero) begin
      ram_we    = 1'b1;
    end else if (cmd.len_lo) begin
      ram_we    = 1'b1;
      ram_waddr = LEN_WORD;
      ram_wdata = bits[31:0];
    end else if (cmd.len_hi) begin
      ram_we    = 1'b1;
      ram_waddr = LEN_WORD + 4'd1;
      ram_wdata = bits[63:32];
    end
    ram_raddr = cmd.load_work ? 4'd0 : msg_index(round + 6'd1);
  end

  // one MD5 round
  always_comb begin
    case (round[5:4])
      2'd0:    f = (wb & wc) | (~wb & wd);
      2'd1:    f = (wb & wd) | (wc & ~wd);
      2'd2:    f = wb ^ wc ^ wd;
      default: f = wc ^ (wb | ~wd);
    endcase
    t     = wa + f + ram_rdata + k_const(round);
    rot2  = {t, t} << rot_amt(round);
    rot   = rot2[63:32];
    b_new = wb + rot;
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) acc <= acc_next;
    if (cmd.load_work) begin
      wa <= chain[0]; wb <= chain[1]; wc <= chain[2]; wd <= chain[3];
    end else if (cmd.do_round) begin
      wa <= wd; wd <= wc; wc <= wb; wb <= b_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cmd.emit && out_idx == LAST_WORD)) begin
      chain[0] <= INIT_A; chain[1] <= INIT_B;
      chain[2] <= INIT_C; chain[3] <= INIT_D;
      fill     <= '0;
      bits     <= '0;
      out_idx  <= '0;
      round    <= '0;
      widx     <= '0;
      pad_wrap <= 1'b0;
    end else begin
      if (cmd.take_byte) begin
        fill <= fill + 6'd1;
        bits <= bits + 64'd8;
      end
      if (cmd.add_chain) begin
        chain[0] <= chain[0] + wa; chain[1] <= chain[1] + wb;
        chain[2] <= chain[2] + wc; chain[3] <= chain[3] + wd;
      end
      if (cmd.load_work) round <= '0;
      else if (cmd.do_round) round <= round + 6'd1;
      if (cmd.pad_first) begin
        widx     <= fill[5:2] + 4'd1;
        pad_wrap <= (fill[5:2] >= LEN_WORD);
      end else if (cmd.pad_zero) begin
        widx <= widx + 4'd1;
      end
      if (cmd.pad_unwrap) pad_wrap <= 1'b0;
      if (cmd.emit) out_idx <= out_idx + 2'd1;
    end
  end

  assign st.fill_full    = (fill == 6'h3F);
  assign st.round_last   = (round == 6'h3F);
  assign st.pad_wrap     = pad_wrap;
  assign st.widx_is_len  = (widx == LEN_WORD);
  assign st.widx_is_zero = (widx == 4'd0);
  assign st.word_last    = (out_idx == LAST_WORD);

  assign digest_word = chain[out_idx];
  assign word_index  = out_idx;
  assign final_word  = (out_idx == LAST_WORD);
endmodule

// ----- sv/md5_ctrl.sv -----
module md5_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  md5_pkg::status_t st,
  output md5_pkg::cmd_t    cmd,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready
);
  import md5_pkg::*;

  state_t state, state_next;
  ret_t   ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= RET_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (st.fill_full) begin
            ret_next   = in_last ? RET_PAD_FIRST : RET_IDLE;
            state_next = S_CLOAD;
          end else if (in_last) begin
            state_next = S_PAD_FIRST;
          end
        end
      end
      S_CLOAD: begin
        cmd.load_work = 1'b1;
        state_next    = S_CROUND;
      end
      S_CROUND: begin
        cmd.do_round = 1'b1;
        if (st.round_last) state_next = S_CADD;
      end
      S_CADD: begin
        cmd.add_chain = 1'b1;
        unique case (ret)
          RET_IDLE:      state_next = S_IDLE;
          RET_PAD_FIRST: state_next = S_PAD_FIRST;
          RET_PAD_ZERO:  state_next = S_PAD_ZERO;
          RET_OUT:       state_next = S_OUT;
          default:       state_next = S_IDLE;
        endcase
      end
      S_PAD_FIRST: begin
        cmd.pad_first = 1'b1;
        state_next    = S_PAD_ZERO;
      end
      S_PAD_ZERO: begin
        if (!st.pad_wrap && st.widx_is_len) begin
          state_next = S_LEN_LO;
        end else if (st.pad_wrap && st.widx_is_zero) begin
          cmd.pad_unwrap = 1'b1;
          ret_next       = RET_PAD_ZERO;
          state_next     = S_CLOAD;
        end else begin
          cmd.pad_zero = 1'b1;
        end
      end
      S_LEN_LO: begin
        cmd.len_lo = 1'b1;
        state_next = S_LEN_HI;
      end
      S_LEN_HI: begin
        cmd.len_hi = 1'b1;
        ret_next   = RET_OUT;
        state_next = S_CLOAD;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (st.word_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- sv/md5_checker.sv -----
`include "md5_message_digest_macros.svh"

module md5_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);
  `MD5_ASSERT(no_intake_in_output, clk, rst, m_tvalid |-> !s_tready)
  `MD5_ASSERT(tlast_on_word_d, clk, rst, (m_tvalid && m_tlast) |-> (m_tuser == 2'd3))
  `MD5_ASSERT(word_order, clk, rst, (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && (m_tuser == 2'($past(m_tuser) + 2'd1))))
  `MD5_ASSERT(no_result_plain_byte, clk, rst, (s_tvalid && s_tready && !s_tlast) |=> !m_tvalid)
  `MD5_ASSERT(hold_stalled, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
endmodule

bind md5_message_digest md5_checker u_md5_checker (.*);
